>>> hw/rtl/kwm_pkg.sv
package kwm_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_PULL = 1'b1
   } op_type;

   typedef enum logic {
      CSR_ROW_COUNT  = 1'b0,
      CSR_ROW_LENGTH = 1'b1
   } csr_index_type;

   localparam int VALUE_W      = 32;
   localparam int ROW_SEL_W    = 3;
   localparam int COL_SEL_W    = 4;
   localparam int ROW_COUNT_W  = 4;
   localparam int ROW_LENGTH_W = 5;
   localparam int CSR_DATA_W   = 5;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 40;
   localparam int RSP_PAD_W    = RSP_DATA_W - VALUE_W - ROW_SEL_W;

   localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RESET  = 4'd8;
   localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RESET = 5'd16;

   typedef struct packed {
      logic clear;
      logic valid;
      logic live;
   } cand_ctl_type;

endpackage

>>> hw/rtl/kwm_ram.sv
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/kwm_min_unit.sv
module kwm_min_unit #(
   parameter int ROW_W  = 3,
   parameter int HEAD_W = 5,
   parameter int REM_W  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kwm_pkg::cand_ctl_type               cand_ctl,
   input  logic signed [kwm_pkg::VALUE_W-1:0]  cand_value,
   input  logic [ROW_W-1:0]                    cand_row,
   input  logic [HEAD_W-1:0]                   cand_head,
   input  logic [HEAD_W-1:0]                   cand_remain,
   output logic                                found,
   output logic signed [kwm_pkg::VALUE_W-1:0]  best_value,
   output logic [ROW_W-1:0]                    best_row,
   output logic [HEAD_W-1:0]                   best_head,
   output logic [REM_W-1:0]                    remain
);

   logic                               found_ff, found_in;
   logic [REM_W-1:0]                   remain_ff, remain_in;
   logic signed [kwm_pkg::VALUE_W-1:0] best_value_ff;
   logic [ROW_W-1:0]                   best_row_ff;
   logic [HEAD_W-1:0]                  best_head_ff;
   logic                               live;
   logic                               take;

   // Strict less-than keeps the lower row on equal values, since rows arrive in order.
   always_comb begin
      live      = cand_ctl.valid && cand_ctl.live;
      take      = live && (!found_ff || (cand_value < best_value_ff));
      found_in  = cand_ctl.clear ? 1'b0 : (found_ff || live);
      remain_in = cand_ctl.clear ? '0
                : (live ? remain_ff + REM_W'(cand_remain) : remain_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         found_ff  <= found_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_value_ff <= cand_value;
         best_row_ff   <= cand_row;
         best_head_ff  <= cand_head;
      end
   end

   assign found      = found_ff;
   assign best_value = best_value_ff;
   assign best_row   = best_row_ff;
   assign best_head  = best_head_ff;
   assign remain     = remain_ff;

endmodule

>>> hw/rtl/k_way_sorted_merge_unit.sv
// K-way sorted merge unit.
// The request channel (req_) carries two kinds of transfer, chosen by req_tuser.
// A load transfer writes one value into the row store at (row_sel, column_sel)
// and rewinds every row to its first element; it returns nothing.
// A pull transfer returns the smallest remaining row head with its row number on
// the response channel (rsp_), with rsp_tlast set on the last element of the
// merge and rsp_tuser set when nothing was left to give.
// A pull walks the active rows one per cycle through a single comparator, fed by
// the head position memory and the row store memory in a two-stage read pipeline.
// Once the scan has drained, the result is committed and the block returns to idle.
// The result sits in an output register: if the receiver stalls, the block still
// takes loads, and a further pull waits in its final step until the slot is free.
// The csr_ port writes row_count (index 0) and row_length (index 1); the user must
// write them only while the block is idle, as the block itself does not enforce it.
// Reset sets row_count to 8 and row_length to 16 and rewinds all rows; the row store
// keeps no reset value and must be loaded before it is read.
module k_way_sorted_merge_unit #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row_sel[2:0], column_sel[6:3], element_value[38:7], zero[39]
   input  logic [kwm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // op[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // merged_value[31:0], source_row[34:32], zero[39:35]
   output logic [kwm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   // exhausted[0]
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [0:0]                          csr_addr,
   input  logic [kwm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int ROWC_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int HEAD_W  = $clog2(MAX_COLS + 1);
   localparam int STORE_D = MAX_ROWS * (2 ** COL_W);
   localparam int STORE_A = $clog2(STORE_D);
   localparam int REM_W   = $clog2(MAX_ROWS * MAX_COLS + 1);

   kwm_pkg::state_type state_ff, state_in;

   logic [kwm_pkg::ROW_COUNT_W-1:0]  row_count_ff, row_count_in;
   logic [kwm_pkg::ROW_LENGTH_W-1:0] row_length_ff, row_length_in;
   logic [ROWC_W-1:0]                rows_eff;
   logic [HEAD_W-1:0]                len_eff;

   logic [kwm_pkg::ROW_SEL_W-1:0]     req_row_sel;
   logic [kwm_pkg::COL_SEL_W-1:0]     req_column_sel;
   logic [kwm_pkg::VALUE_W-1:0]       req_element_value;
   logic                              req_fire;
   logic                              load_fire;
   logic                              pull_fire;
   logic                              load_ok;

   logic                              issue;
   logic                              commit;
   logic [ROWC_W-1:0]                 iss_ff, iss_in;

   logic [MAX_ROWS-1:0]               valid_ff, valid_in;
   logic [HEAD_W-1:0]                 head_rdata;
   logic                              head_we;
   logic [HEAD_W-1:0]                 head_wdata;

   logic                              store_we;
   logic [STORE_A-1:0]                store_waddr;
   logic [STORE_A-1:0]                store_raddr;
   logic [kwm_pkg::VALUE_W-1:0]       store_rdata;

   logic                              s1_v_ff;
   logic [ROW_W-1:0]                  s1_row_ff;
   logic [HEAD_W-1:0]                 s1_head;
   logic                              s1_live;
   logic                              s2_v_ff;
   logic [ROW_W-1:0]                  s2_row_ff;
   logic [HEAD_W-1:0]                 s2_head_ff;
   logic                              s2_live_ff;
   logic [HEAD_W-1:0]                 s2_remain;

   kwm_pkg::cand_ctl_type             cand_ctl;
   logic                              found;
   logic signed [kwm_pkg::VALUE_W-1:0] best_value;
   logic [ROW_W-1:0]                  best_row;
   logic [HEAD_W-1:0]                 best_head;
   logic [REM_W-1:0]                  remain;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [kwm_pkg::VALUE_W-1:0]       rsp_value_ff;
   logic [kwm_pkg::ROW_SEL_W-1:0]     rsp_row_ff;
   logic                              rsp_final_ff;
   logic                              rsp_exh_ff;

   assign req_row_sel       = req_tdata[2:0];
   assign req_column_sel    = req_tdata[6:3];
   assign req_element_value = req_tdata[38:7];

   assign req_tready = (state_ff == kwm_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == kwm_pkg::OP_LOAD);
   assign pull_fire  = req_fire && (req_tuser == kwm_pkg::OP_PULL);

   always_comb begin
      rows_eff = (int'(row_count_ff) > MAX_ROWS) ? ROWC_W'(MAX_ROWS) : ROWC_W'(row_count_ff);
      len_eff  = (int'(row_length_ff) > MAX_COLS) ? HEAD_W'(MAX_COLS)
               : HEAD_W'(row_length_ff);
   end

   always_comb begin
      row_count_in  = row_count_ff;
      row_length_in = row_length_ff;
      if (csr_we) begin
         unique case (kwm_pkg::csr_index_type'(csr_addr))
            kwm_pkg::CSR_ROW_COUNT:  row_count_in  = csr_wdata[kwm_pkg::ROW_COUNT_W-1:0];
            kwm_pkg::CSR_ROW_LENGTH: row_length_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= kwm_pkg::ROW_COUNT_RESET;
         row_length_ff <= kwm_pkg::ROW_LENGTH_RESET;
      end else begin
         row_count_ff  <= row_count_in;
         row_length_ff <= row_length_in;
      end
   end

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (pull_fire) begin
               state_in = kwm_pkg::ST_SCAN;
            end
         end
         kwm_pkg::ST_SCAN: begin
            if (iss_ff >= rows_eff) begin
               state_in = kwm_pkg::ST_DRAIN;
            end
         end
         kwm_pkg::ST_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               state_in = kwm_pkg::ST_COMMIT;
            end
         end
         kwm_pkg::ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = kwm_pkg::ST_IDLE;
            end
         end
         default: state_in = kwm_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      issue  = 1'b0;
      commit = 1'b0;
      unique case (state_ff)
         kwm_pkg::ST_IDLE:   ;
         kwm_pkg::ST_SCAN:   issue  = (iss_ff < rows_eff);
         kwm_pkg::ST_DRAIN:  ;
         kwm_pkg::ST_COMMIT: commit = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_comb begin
      iss_in = pull_fire ? '0 : (issue ? iss_ff + ROWC_W'(1) : iss_ff);
      valid_in = valid_ff;
      if (load_fire) begin
         valid_in = '0;
      end else if (commit && found) begin
         valid_in[best_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kwm_pkg::ST_IDLE;
         iss_ff   <= '0;
         valid_ff <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         iss_ff   <= iss_in;
         valid_ff <= valid_in;
         s1_v_ff  <= issue;
         s2_v_ff  <= s1_v_ff;
      end
   end

   assign load_ok = (int'(req_row_sel) < MAX_ROWS) && (int'(req_column_sel) < MAX_COLS);
   assign store_we    = load_fire && load_ok;
   assign store_waddr = {ROW_W'(req_row_sel), COL_W'(req_column_sel)};

   assign head_we    = commit && found;
   assign head_wdata = best_head + HEAD_W'(1);

   kwm_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (MAX_ROWS)
   ) u_head_ram (
      .clock (clock),
      .we    (head_we),
      .waddr (best_row),
      .wdata (head_wdata),
      .raddr (iss_ff[ROW_W-1:0]),
      .rdata (head_rdata)
   );

   // A row whose valid bit is clear has been rewound and stands at its first element.
   always_comb begin
      s1_head     = valid_ff[s1_row_ff] ? head_rdata : '0;
      s1_live     = s1_head < len_eff;
      store_raddr = {s1_row_ff, s1_head[COL_W-1:0]};
   end

   kwm_ram #(
      .WIDTH (kwm_pkg::VALUE_W),
      .DEPTH (STORE_D)
   ) u_store_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (req_element_value),
      .raddr (store_raddr),
      .rdata (store_rdata)
   );

   always_ff @(posedge clock) begin
      s1_row_ff  <= iss_ff[ROW_W-1:0];
      s2_row_ff  <= s1_row_ff;
      s2_head_ff <= s1_head;
      s2_live_ff <= s1_live;
   end

   assign s2_remain = len_eff - s2_head_ff;
   assign cand_ctl  = '{clear: pull_fire, valid: s2_v_ff, live: s2_live_ff};

   kwm_min_unit #(
      .ROW_W  (ROW_W),
      .HEAD_W (HEAD_W),
      .REM_W  (REM_W)
   ) u_min_unit (
      .clock       (clock),
      .reset       (reset),
      .cand_ctl    (cand_ctl),
      .cand_value  (store_rdata),
      .cand_row    (s2_row_ff),
      .cand_head   (s2_head_ff),
      .cand_remain (s2_remain),
      .found       (found),
      .best_value  (best_value),
      .best_row    (best_row),
      .best_head   (best_head),
      .remain      (remain)
   );

   assign rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_value_ff <= found ? best_value : '0;
         rsp_row_ff   <= found ? kwm_pkg::ROW_SEL_W'(best_row) : '0;
         rsp_final_ff <= found && (remain == REM_W'(1));
         rsp_exh_ff   <= !found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{kwm_pkg::RSP_PAD_W{1'b0}}, rsp_row_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_final_ff;
   assign rsp_tuser  = rsp_exh_ff;

`ifndef SYNTHESIS
   a_pull_starts_scan: assert property (@(posedge clock) disable iff (reset)
      pull_fire |=> (state_ff == kwm_pkg::ST_SCAN))
      else $error("pull transfer did not start a scan");

   a_commit_fills_slot: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_tvalid && (state_ff == kwm_pkg::ST_IDLE)))
      else $error("commit did not load the response register");

   a_exhausted_not_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tlast)
      else $error("exhausted response marked as final element");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff || s2_v_ff) |->
         ((state_ff == kwm_pkg::ST_SCAN) || (state_ff == kwm_pkg::ST_DRAIN)))
      else $error("scan pipeline busy outside of a scan");
`endif

endmodule

>>> tb/tb_k_way_sorted_merge_unit.sv
module tb_k_way_sorted_merge_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ROWS       = 8;
   localparam int MAX_COLS       = 16;
   localparam int DRAIN_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam int VALUE_W      = kwm_pkg::VALUE_W;
   localparam int ROW_SEL_W    = kwm_pkg::ROW_SEL_W;
   localparam int COL_SEL_W    = kwm_pkg::COL_SEL_W;
   localparam int ROW_COUNT_W  = kwm_pkg::ROW_COUNT_W;
   localparam int ROW_LENGTH_W = kwm_pkg::ROW_LENGTH_W;
   localparam int CSR_DATA_W   = kwm_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W   = kwm_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W   = kwm_pkg::RSP_DATA_W;

   typedef struct packed {
      logic [VALUE_W-1:0]   value;
      logic [ROW_SEL_W-1:0] row;
      logic                 last;
      logic                 empty;
   } merge_result_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;
   logic                    csr_we     = 1'b0;
   logic [0:0]              csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   logic signed [VALUE_W-1:0] row_image [MAX_ROWS][MAX_COLS];
   logic [ROW_LENGTH_W-1:0]   head_pos [MAX_ROWS];
   logic [ROW_COUNT_W-1:0]    merge_rows;
   logic [ROW_LENGTH_W-1:0]   merge_len;

   merge_result_type pending_merges[$];
   merge_result_type next_result;
   int            error_count = 0;
   int            items_sent  = 0;
   int            idle_cycles = 0;
   bit            steady_flow = 1'b0;

   k_way_sorted_merge_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Returns the row with the smallest live head, lowest row on ties, or -1.
   function automatic int smallest_head();
      int best;
      int rows;
      int len;
      logic signed [VALUE_W-1:0] best_val;
      rows = (merge_rows > MAX_ROWS) ? MAX_ROWS : merge_rows;
      len  = (merge_len > MAX_COLS) ? MAX_COLS : merge_len;
      best = -1;
      best_val = '0;
      for (int r = 0; r < rows; r++) begin
         if (head_pos[r] < len) begin
            if (best < 0 || row_image[r][head_pos[r]] < best_val) begin
               best = r;
               best_val = row_image[r][head_pos[r]];
            end
         end
      end
      return best;
   endfunction

   function automatic void merge_apply(input kwm_pkg::op_type op,
                                       input logic [ROW_SEL_W-1:0] row,
                                       input logic [COL_SEL_W-1:0] col,
                                       input logic [VALUE_W-1:0] value);
      merge_result_type res;
      int r;
      res = '0;
      if (op == kwm_pkg::OP_LOAD) begin
         row_image[row][col] = value;
         foreach (head_pos[i]) head_pos[i] = '0;
      end else begin
         r = smallest_head();
         if (r < 0) begin
            res.empty = 1'b1;
         end else begin
            res.value = row_image[r][head_pos[r]];
            res.row   = r[ROW_SEL_W-1:0];
            head_pos[r] = head_pos[r] + ROW_LENGTH_W'(1);
            res.last  = (smallest_head() < 0);
         end
         pending_merges.insert(pending_merges.size(), res);
      end
   endfunction

   always @(posedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 32);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_merges.size() == 0) begin
            $error("rsp transfer with no pending result: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            next_result = pending_merges.pop_front();
            if (rsp_tdata[VALUE_W-1:0] !== next_result.value) begin
               $error("merged_value: expected %0d, actual %0d", $signed(next_result.value),
                      $signed(rsp_tdata[VALUE_W-1:0]));
               error_count++;
            end
            if (rsp_tdata[VALUE_W+ROW_SEL_W-1:VALUE_W] !== next_result.row) begin
               $error("source_row: expected %0d, actual %0d", next_result.row,
                      rsp_tdata[VALUE_W+ROW_SEL_W-1:VALUE_W]);
               error_count++;
            end
            if (rsp_tlast !== next_result.last) begin
               $error("final_element: expected %0b, actual %0b", next_result.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== next_result.empty) begin
               $error("exhausted: expected %0b, actual %0b", next_result.empty, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_item(input kwm_pkg::op_type op, input logic [ROW_SEL_W-1:0] row,
                            input logic [COL_SEL_W-1:0] col, input logic [VALUE_W-1:0] value);
      while (!steady_flow && $urandom_range(0, 99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, value, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      merge_apply(op, row, col, value);
   endtask

   task automatic load_element(input logic [ROW_SEL_W-1:0] row, input logic [COL_SEL_W-1:0] col,
                               input logic [VALUE_W-1:0] value);
      send_item(kwm_pkg::OP_LOAD, row, col, value);
   endtask

   task automatic pull_next();
      send_item(kwm_pkg::OP_PULL, ROW_SEL_W'($urandom_range(0, 7)),
                COL_SEL_W'($urandom_range(0, 15)), $urandom);
   endtask

   // Loads are silent, so the block may still be busy once the last result is in.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_merges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input kwm_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] data);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == kwm_pkg::CSR_ROW_COUNT) merge_rows = data[ROW_COUNT_W-1:0];
      else merge_len = data[ROW_LENGTH_W-1:0];
   endtask

   task automatic set_shape(input int rows, input int len);
      write_csr(kwm_pkg::CSR_ROW_COUNT, CSR_DATA_W'(rows));
      write_csr(kwm_pkg::CSR_ROW_LENGTH, CSR_DATA_W'(len));
   endtask

   task automatic load_sorted_rows(input int rows, input int len);
      longint cur;
      int mode;
      for (int r = 0; r < rows; r++) begin
         mode = $urandom_range(0, 3);
         case (mode)
            0: cur = -64'sd2147483648;
            1: cur = longint'($urandom_range(0, 4)) - 2;
            2: cur = longint'(int'($urandom));
            default: cur = 64'sd2147483647 - longint'($urandom_range(0, 40));
         endcase
         for (int c = 0; c < len; c++) begin
            if (cur > 64'sd2147483647) cur = 64'sd2147483647;
            load_element(r[ROW_SEL_W-1:0], c[COL_SEL_W-1:0], cur[VALUE_W-1:0]);
            case (mode)
               0, 1: cur += $urandom_range(0, 2);
               2: cur += $urandom_range(0, 1 << 26);
               default: cur += $urandom_range(0, 5);
            endcase
         end
      end
   endtask

   // The whole store is written up front so no pull can ever read an empty entry.
   task automatic test_full_merge();
      load_sorted_rows(MAX_ROWS, MAX_COLS);
      repeat (MAX_ROWS * MAX_COLS + 1) pull_next();
      settle();
   endtask

   task automatic test_directed();
      set_shape(2, 2);
      load_element(3'd0, 4'd0, 32'h8000_0000);
      load_element(3'd0, 4'd1, 32'd5);
      load_element(3'd1, 4'd0, 32'd5);
      load_element(3'd1, 4'd1, 32'h7fff_ffff);
      repeat (5) pull_next();
      set_shape(0, 16);
      pull_next();
      set_shape(8, 0);
      pull_next();
      set_shape(15, 1);
      load_element(3'd7, 4'd15, 32'hffff_ffff);
      repeat (9) pull_next();
      settle();
   endtask

   task automatic test_random_merges(input int target);
      int rows;
      int len;
      int eff_rows;
      int eff_len;
      int n_pulls;
      int cut;
      bit broken;
      while (items_sent < target) begin
         case ($urandom_range(0, 19))
            0: rows = 0;
            1: rows = MAX_ROWS;
            2: rows = $urandom_range(9, 15);
            default: rows = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 19))
            0: len = 0;
            1: len = $urandom_range(16, 31);
            default: len = $urandom_range(1, 5);
         endcase
         set_shape(rows, len);
         eff_rows = (rows > MAX_ROWS) ? MAX_ROWS : rows;
         eff_len  = (len > MAX_COLS) ? MAX_COLS : len;
         load_sorted_rows(eff_rows, eff_len);
         n_pulls = eff_rows * eff_len + $urandom_range(0, 2);
         broken  = ($urandom_range(0, 9) == 0);
         cut     = $urandom_range(0, n_pulls);
         for (int i = 0; i < n_pulls; i++) begin
            if (broken && i == cut) load_element(ROW_SEL_W'($urandom_range(0, 7)),
                                                 COL_SEL_W'($urandom_range(0, 15)), $urandom);
            pull_next();
         end
      end
      settle();
   endtask

   task automatic test_steady_stream(input int target);
      steady_flow = 1'b1;
      test_random_merges(target);
      steady_flow = 1'b0;
   endtask

   task automatic test_random_noise(input int target);
      int pick;
      set_shape(3, 3);
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            pull_next();
         end else if (pick < 92) begin
            load_element(ROW_SEL_W'($urandom_range(0, 7)), COL_SEL_W'($urandom_range(0, 15)),
                         $urandom);
         end else begin
            write_csr(kwm_pkg::csr_index_type'($urandom_range(0, 1)),
                      CSR_DATA_W'($urandom_range(0, 31)));
         end
      end
      settle();
   endtask

   initial begin
      foreach (head_pos[i]) head_pos[i] = '0;
      merge_rows = kwm_pkg::ROW_COUNT_RESET;
      merge_len  = kwm_pkg::ROW_LENGTH_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_merge();
      test_directed();
      test_random_merges(items_sent + 550);
      test_steady_stream(items_sent + 200);
      test_random_noise(items_sent + 300);
      settle();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_ram.sv
hw/rtl/kwm_min_unit.sv
hw/rtl/k_way_sorted_merge_unit.sv
tb/tb_k_way_sorted_merge_unit.sv
